// File: design/ipdr_pkg.sv
`default_nettype none
package ipdr_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int DT_BITS          = 16;
   localparam int WORD_W           = 32;
   localparam int NUM_ENTRIES      = 12;
   localparam int ADDR_W           = $clog2(NUM_ENTRIES);
   localparam int CSR_IDX_W        = 4;

   typedef logic signed [69:0] wide_type;
   typedef logic signed [32:0] opnd_type;
   typedef logic signed [65:0] prod_type;
   typedef logic signed [33:0] rot_type;

   // State memory map.
   localparam logic [ADDR_W-1:0] ST_PX = 4'd0;
   localparam logic [ADDR_W-1:0] ST_PY = 4'd1;
   localparam logic [ADDR_W-1:0] ST_HD = 4'd2;
   localparam logic [ADDR_W-1:0] ST_VX = 4'd3;
   localparam logic [ADDR_W-1:0] ST_VY = 4'd4;
   localparam logic [ADDR_W-1:0] ST_XX = 4'd5;
   localparam logic [ADDR_W-1:0] ST_XY = 4'd6;
   localparam logic [ADDR_W-1:0] ST_XH = 4'd7;
   localparam logic [ADDR_W-1:0] ST_YY = 4'd8;
   localparam logic [ADDR_W-1:0] ST_YH = 4'd9;
   localparam logic [ADDR_W-1:0] ST_HH = 4'd10;
   localparam logic [ADDR_W-1:0] ST_VV = 4'd11;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMU_PRESENT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_BIAS_X  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_BIAS_Y  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_BIAS   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_X   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_Y   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACC_NOISE   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_NOISE  = 4'd7;

   localparam logic ACTION_INIT = 1'b0;

   localparam opnd_type K_TWO_OVER_PI = 33'sd683565276;
   localparam opnd_type K_HALF_PI     = 33'sd1686629713;
   localparam rot_type  K_INV_GAIN    = 34'sd652032874;
   localparam rot_type  K_Q30_ONE     = 34'sd1073741824;

   localparam wide_type W_MAX = 70'sd2147483647;
   localparam wide_type W_MIN = -70'sd2147483648;

   function automatic logic signed [31:0] sat32(wide_type x);
      logic signed [31:0] r;
      if (x > W_MAX) r = 32'sh7fffffff;
      else if (x < W_MIN) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] satu31(wide_type x);
      logic signed [31:0] r;
      if (x > W_MAX) r = 32'sh7fffffff;
      else if (x < 0) r = '0;
      else r = x[31:0];
      return r;
   endfunction

   // Round half up, then shift right arithmetically.
   function automatic wide_type rnd(wide_type x, int s);
      wide_type bias;
      bias = wide_type'(1) <<< (s - 1);
      return (x + bias) >>> s;
   endfunction

   function automatic rot_type atan_q30(int i);
      rot_type r;
      unique case (i)
         0:  r = 34'sd843314857;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043837;
         3:  r = 34'sd133525159;
         4:  r = 34'sd67021687;
         5:  r = 34'sd33543516;
         6:  r = 34'sd16775851;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194283;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048576;
         11: r = 34'sd524288;
         12: r = 34'sd262144;
         13: r = 34'sd131072;
         14: r = 34'sd65536;
         15: r = 34'sd32768;
         16: r = 34'sd16384;
         17: r = 34'sd8192;
         18: r = 34'sd4096;
         19: r = 34'sd2048;
         20: r = 34'sd1024;
         21: r = 34'sd512;
         22: r = 34'sd256;
         23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/ipdr_if.sv
`default_nettype none
interface ipdr_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] meas_acc_x;
   logic signed [31:0] meas_acc_y;
   logic signed [31:0] meas_yaw_rate;
   logic [15:0]        step_time;
   logic signed [31:0] init_pos_x;
   logic signed [31:0] init_pos_y;
   logic signed [31:0] init_heading;
   logic signed [31:0] init_vel_x;
   logic signed [31:0] init_vel_y;

   modport source (output valid, action, meas_acc_x, meas_acc_y, meas_yaw_rate, step_time,
                   init_pos_x, init_pos_y, init_heading, init_vel_x, init_vel_y,
                   input ready);
   modport sink (input valid, action, meas_acc_x, meas_acc_y, meas_yaw_rate, step_time,
                 init_pos_x, init_pos_y, init_heading, init_vel_x, init_vel_y,
                 output ready);
endinterface

interface ipdr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_heading;
   logic signed [31:0] out_vel_x;
   logic signed [31:0] out_vel_y;
   logic [30:0]        cov_xx;
   logic signed [31:0] cov_xy;
   logic signed [31:0] cov_xh;
   logic [30:0]        cov_yy;
   logic signed [31:0] cov_yh;
   logic [30:0]        cov_hh;
   logic [30:0]        vel_variance;

   modport source (output valid, out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y,
                   cov_xx, cov_xy, cov_xh, cov_yy, cov_yh, cov_hh, vel_variance,
                   input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y,
                 cov_xx, cov_xy, cov_xh, cov_yy, cov_yh, cov_hh, vel_variance,
                 output ready);
endinterface

interface ipdr_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/ipdr_state_mem.sv
`default_nettype none
module ipdr_state_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [ipdr_pkg::ADDR_W-1:0]         wr_addr,
   input  logic [ipdr_pkg::WORD_W-1:0]         wr_data,
   input  logic [ipdr_pkg::ADDR_W-1:0]         rd_addr,
   output logic [ipdr_pkg::WORD_W-1:0]         rd_data
);
   import ipdr_pkg::*;

   logic [WORD_W-1:0]      mem_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0]      rd_q_ff;
   logic                   rd_vld_ff;

   // An entry that was never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_addr < ADDR_W'(NUM_ENTRIES)) rd_vld_ff <= valid_ff[rd_addr];
         else rd_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_addr < ADDR_W'(NUM_ENTRIES)) rd_q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;
endmodule
`default_nettype wire

// File: design/ipdr_mul.sv
`default_nettype none
module ipdr_mul (
   input  logic               clock,
   input  logic               en,
   input  ipdr_pkg::opnd_type op_a,
   input  ipdr_pkg::opnd_type op_b,
   output ipdr_pkg::prod_type prod
);
   import ipdr_pkg::*;

   prod_type prod_ff;

   always_ff @(posedge clock) begin
      if (en) prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// File: design/ipdr_cordic.sv
`default_nettype none
module ipdr_cordic #(
   parameter int CORDIC_STEPS = ipdr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ipdr_pkg::rot_type   z0,
   output logic                done,
   output logic signed [31:0]  cos_q30,
   output logic signed [31:0]  sin_q30
);
   import ipdr_pkg::*;

   localparam int CNT_W = $clog2(CORDIC_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rot_type          x_ff, x_in, y_ff, y_in, z_ff, z_in;

   always_comb begin
      rot_type dx, dy, ang;
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      ang     = atan_q30(int'(cnt_ff));
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = K_INV_GAIN;
         y_in    = '0;
         z_in    = z0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   always_comb begin
      if (x_ff > K_Q30_ONE) cos_q30 = K_Q30_ONE[31:0];
      else if (x_ff < -K_Q30_ONE) cos_q30 = 32'(-K_Q30_ONE);
      else cos_q30 = x_ff[31:0];
      if (y_ff > K_Q30_ONE) sin_q30 = K_Q30_ONE[31:0];
      else if (y_ff < -K_Q30_ONE) sin_q30 = 32'(-K_Q30_ONE);
      else sin_q30 = y_ff[31:0];
   end

   assign done = done_ff;
endmodule
`default_nettype wire

// File: design/planar_imu_dead_reckoning.sv
`default_nettype none
// Channel  Dir  Handshake     Beat contents
// req_bus  in   valid/ready   action, measurements, step_time, initial pose and velocity
// rsp_bus  out  valid/ready   pose, velocity, covariance entries, velocity variance
// csr_bus  in   valid/ready   register index and write data, always ready
//
// From acceptance to its result beat, every item runs these steps in order: the state
// memory is read; 34 operations run on the one shared multiplier, each through S_OPA
// and S_OPB, with the CORDIC run after the angle operation OP_ZANG; the state is
// written back; and the result register is loaded once the result slot is free.
// An initialize item or a step without an IMU skips the multiplier work and the CORDIC.
// Reset clears the configuration registers, control state and memory valid bits; no clearing pass.
// The next item is taken while a result beat still waits; its result waits for the slot.
module planar_imu_dead_reckoning #(
   parameter int FRAC_BITS    = ipdr_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = ipdr_pkg::CORDIC_STEPS_DEF
) (
   input logic         clock,
   input logic         reset,
   ipdr_req_if.sink    req_bus,
   ipdr_rsp_if.source  rsp_bus,
   ipdr_csr_if.sink    csr_bus
);
   import ipdr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_OPA   = 3'd2;
   localparam logic [2:0] S_OPB   = 3'd3;
   localparam logic [2:0] S_CORD  = 3'd4;
   localparam logic [2:0] S_STORE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [5:0] OP_DTDT = 6'd0;
   localparam logic [5:0] OP_HDHD = 6'd1;
   localparam logic [5:0] OP_QUAD = 6'd2;
   localparam logic [5:0] OP_ZANG = 6'd3;
   localparam logic [5:0] OP_CAX  = 6'd4;
   localparam logic [5:0] OP_SAY  = 6'd5;
   localparam logic [5:0] OP_SAX  = 6'd6;
   localparam logic [5:0] OP_CAY  = 6'd7;
   localparam logic [5:0] OP_HEAD = 6'd8;
   localparam logic [5:0] OP_PX1  = 6'd9;
   localparam logic [5:0] OP_PX2  = 6'd10;
   localparam logic [5:0] OP_PY1  = 6'd11;
   localparam logic [5:0] OP_PY2  = 6'd12;
   localparam logic [5:0] OP_VX   = 6'd13;
   localparam logic [5:0] OP_VY   = 6'd14;
   localparam logic [5:0] OP_A    = 6'd15;
   localparam logic [5:0] OP_B    = 6'd16;
   localparam logic [5:0] OP_ACCV = 6'd17;
   localparam logic [5:0] OP_GYRV = 6'd18;
   localparam logic [5:0] OP_QP   = 6'd19;
   localparam logic [5:0] OP_XX1  = 6'd20;
   localparam logic [5:0] OP_XX2  = 6'd21;
   localparam logic [5:0] OP_XX3  = 6'd22;
   localparam logic [5:0] OP_XY1  = 6'd23;
   localparam logic [5:0] OP_XY2  = 6'd24;
   localparam logic [5:0] OP_XY3  = 6'd25;
   localparam logic [5:0] OP_XY4  = 6'd26;
   localparam logic [5:0] OP_YY1  = 6'd27;
   localparam logic [5:0] OP_YY2  = 6'd28;
   localparam logic [5:0] OP_YY3  = 6'd29;
   localparam logic [5:0] OP_XH   = 6'd30;
   localparam logic [5:0] OP_YH   = 6'd31;
   localparam logic [5:0] OP_HH   = 6'd32;
   localparam logic [5:0] OP_VV   = 6'd33;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam int SH_N = FRAC_BITS + 30;

   // Configuration registers.
   logic               imu_present_ff;
   logic signed [31:0] acc_bias_x_ff, acc_bias_y_ff, gyro_bias_ff;
   logic signed [31:0] gravity_x_ff, gravity_y_ff;
   logic [30:0]        acc_noise_ff, gyro_noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         imu_present_ff <= 1'b0;
         acc_bias_x_ff  <= '0;
         acc_bias_y_ff  <= '0;
         gyro_bias_ff   <= '0;
         gravity_x_ff   <= '0;
         gravity_y_ff   <= '0;
         acc_noise_ff   <= '0;
         gyro_noise_ff  <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_IMU_PRESENT: imu_present_ff <= csr_bus.data[0];
            CSR_ACC_BIAS_X:  acc_bias_x_ff  <= csr_bus.data;
            CSR_ACC_BIAS_Y:  acc_bias_y_ff  <= csr_bus.data;
            CSR_GYRO_BIAS:   gyro_bias_ff   <= csr_bus.data;
            CSR_GRAVITY_X:   gravity_x_ff   <= csr_bus.data;
            CSR_GRAVITY_Y:   gravity_y_ff   <= csr_bus.data;
            CSR_ACC_NOISE:   acc_noise_ff   <= csr_bus.data[30:0];
            CSR_GYRO_NOISE:  gyro_noise_ff  <= csr_bus.data[30:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // Sequencer state and working registers.
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [5:0]        op_ff, op_in;
   logic signed [31:0] st_ff [NUM_ENTRIES];
   logic signed [31:0] st_in [NUM_ENTRIES];
   logic signed [31:0] out_ff [NUM_ENTRIES];
   logic signed [31:0] out_in [NUM_ENTRIES];
   logic               rsp_valid_ff, rsp_valid_in;

   logic               action_ff, action_in;
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in, w_ff, w_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] ipx_ff, ipx_in, ipy_ff, ipy_in, ihd_ff, ihd_in;
   logic signed [31:0] ivx_ff, ivx_in, ivy_ff, ivy_in;

   logic [16:0]        hd2_ff, hd2_in, d2_ff, d2_in, q4_ff, q4_in;
   logic [1:0]         nq_ff, nq_in;
   logic signed [31:0] rr_ff, rr_in, c_ff, c_in, s_ff, s_in;
   logic signed [31:0] e1_ff, e1_in, e2_ff, e2_in, awx_ff, awx_in, awy_ff, awy_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, accv_ff, accv_in, gyrv_ff, gyrv_in;
   logic signed [31:0] qp_ff, qp_in, t1_ff, t1_in;
   wide_type           acc_ff, acc_in;

   // Shared multiplier, CORDIC unit and state memory.
   opnd_type           mul_a, mul_b;
   prod_type           prod;
   wide_type           prod_w;
   logic signed [31:0] md, mq;
   logic               cord_start, cord_done;
   rot_type            cord_z0;
   wide_type           z_w;
   logic signed [31:0] cord_c, cord_s;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data;

   ipdr_mul u_mul (
      .clock (clock),
      .en    (state_ff == S_OPA),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   ipdr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .z0      (cord_z0),
      .done    (cord_done),
      .cos_q30 (cord_c),
      .sin_q30 (cord_s)
   );

   ipdr_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (st_ff[cnt_ff]),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign prod_w      = wide_type'(prod);
   assign md          = sat32(rnd(prod_w, DT_BITS));
   assign mq          = sat32(rnd(prod_w, FRAC_BITS));
   assign z_w         = rnd(prod_w, 30);
   assign cord_z0     = z_w[33:0];
   assign cord_start  = (state_ff == S_OPB) && (op_ff == OP_ZANG);
   assign mem_wr_en   = (state_ff == S_STORE);
   assign mem_rd_addr = (state_ff == S_LOAD) ? cnt_ff + 1'b1 : '0;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_DTDT: begin mul_a = opnd_type'({1'b0, dt_ff}); mul_b = mul_a; end
         OP_HDHD: begin mul_a = opnd_type'({1'b0, hd2_ff}); mul_b = mul_a; end
         OP_QUAD: begin mul_a = opnd_type'(st_ff[ST_HD]); mul_b = K_TWO_OVER_PI; end
         OP_ZANG: begin mul_a = opnd_type'(rr_ff); mul_b = K_HALF_PI; end
         OP_CAX:  begin mul_a = opnd_type'(c_ff); mul_b = opnd_type'(ax_ff); end
         OP_SAY:  begin mul_a = opnd_type'(s_ff); mul_b = opnd_type'(ay_ff); end
         OP_SAX:  begin mul_a = opnd_type'(s_ff); mul_b = opnd_type'(ax_ff); end
         OP_CAY:  begin mul_a = opnd_type'(c_ff); mul_b = opnd_type'(ay_ff); end
         OP_HEAD: begin mul_a = opnd_type'(w_ff); mul_b = opnd_type'({1'b0, dt_ff}); end
         OP_PX1:  begin
            mul_a = opnd_type'(st_ff[ST_VX]); mul_b = opnd_type'({1'b0, dt_ff});
         end
         OP_PX2:  begin mul_a = opnd_type'(awx_ff); mul_b = opnd_type'({1'b0, hd2_ff}); end
         OP_PY1:  begin
            mul_a = opnd_type'(st_ff[ST_VY]); mul_b = opnd_type'({1'b0, dt_ff});
         end
         OP_PY2:  begin mul_a = opnd_type'(awy_ff); mul_b = opnd_type'({1'b0, hd2_ff}); end
         OP_VX:   begin mul_a = opnd_type'(awx_ff); mul_b = opnd_type'({1'b0, dt_ff}); end
         OP_VY:   begin mul_a = opnd_type'(awy_ff); mul_b = opnd_type'({1'b0, dt_ff}); end
         OP_A:    begin mul_a = -opnd_type'(e2_ff); mul_b = opnd_type'({1'b0, hd2_ff}); end
         OP_B:    begin mul_a = opnd_type'(e1_ff); mul_b = opnd_type'({1'b0, hd2_ff}); end
         OP_ACCV: begin mul_a = opnd_type'({2'b0, acc_noise_ff}); mul_b = mul_a; end
         OP_GYRV: begin mul_a = opnd_type'({2'b0, gyro_noise_ff}); mul_b = mul_a; end
         OP_QP:   begin mul_a = opnd_type'(accv_ff); mul_b = opnd_type'({1'b0, q4_ff}); end
         OP_XX1:  begin mul_a = opnd_type'(a_ff); mul_b = opnd_type'(st_ff[ST_XH]); end
         OP_XX2:  begin mul_a = opnd_type'(a_ff); mul_b = opnd_type'(a_ff); end
         OP_XX3:  begin mul_a = opnd_type'(t1_ff); mul_b = opnd_type'(st_ff[ST_HH]); end
         OP_XY1:  begin mul_a = opnd_type'(a_ff); mul_b = opnd_type'(st_ff[ST_YH]); end
         OP_XY2:  begin mul_a = opnd_type'(b_ff); mul_b = opnd_type'(st_ff[ST_XH]); end
         OP_XY3:  begin mul_a = opnd_type'(a_ff); mul_b = opnd_type'(b_ff); end
         OP_XY4:  begin mul_a = opnd_type'(t1_ff); mul_b = opnd_type'(st_ff[ST_HH]); end
         OP_YY1:  begin mul_a = opnd_type'(b_ff); mul_b = opnd_type'(st_ff[ST_YH]); end
         OP_YY2:  begin mul_a = opnd_type'(b_ff); mul_b = opnd_type'(b_ff); end
         OP_YY3:  begin mul_a = opnd_type'(t1_ff); mul_b = opnd_type'(st_ff[ST_HH]); end
         OP_XH:   begin mul_a = opnd_type'(a_ff); mul_b = opnd_type'(st_ff[ST_HH]); end
         OP_YH:   begin mul_a = opnd_type'(b_ff); mul_b = opnd_type'(st_ff[ST_HH]); end
         OP_HH:   begin mul_a = opnd_type'(gyrv_ff); mul_b = opnd_type'({1'b0, d2_ff}); end
         OP_VV:   begin mul_a = opnd_type'(accv_ff); mul_b = opnd_type'({1'b0, d2_ff}); end
         default: ;
      endcase
   end

   always_comb begin
      wide_type nw, rem, dd;
      nw           = rnd(prod_w, SH_N);
      rem          = prod_w - (nw <<< SH_N);
      dd           = prod_w + (wide_type'(1) <<< 15);
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      st_in        = st_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      w_in         = w_ff;
      dt_in        = dt_ff;
      ipx_in       = ipx_ff;
      ipy_in       = ipy_ff;
      ihd_in       = ihd_ff;
      ivx_in       = ivx_ff;
      ivy_in       = ivy_ff;
      hd2_in       = hd2_ff;
      d2_in        = d2_ff;
      q4_in        = q4_ff;
      nq_in        = nq_ff;
      rr_in        = rr_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      awx_in       = awx_ff;
      awy_in       = awy_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      accv_in      = accv_ff;
      gyrv_in      = gyrv_ff;
      qp_in        = qp_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;

      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               action_in = req_bus.action;
               ax_in  = sat32(wide_type'(req_bus.meas_acc_x) - wide_type'(acc_bias_x_ff));
               ay_in  = sat32(wide_type'(req_bus.meas_acc_y) - wide_type'(acc_bias_y_ff));
               w_in   = sat32(wide_type'(req_bus.meas_yaw_rate) - wide_type'(gyro_bias_ff));
               dt_in  = req_bus.step_time;
               ipx_in = req_bus.init_pos_x;
               ipy_in = req_bus.init_pos_y;
               ihd_in = req_bus.init_heading;
               ivx_in = req_bus.init_vel_x;
               ivy_in = req_bus.init_vel_y;
               cnt_in = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            st_in[cnt_ff] = mem_rd_data;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(NUM_ENTRIES - 1)) begin
               cnt_in = '0;
               op_in  = OP_DTDT;
               if (action_ff == ACTION_INIT) begin
                  for (int i = 0; i < NUM_ENTRIES; i++) st_in[i] = '0;
                  st_in[ST_PX] = ipx_ff;
                  st_in[ST_PY] = ipy_ff;
                  st_in[ST_HD] = ihd_ff;
                  st_in[ST_VX] = ivx_ff;
                  st_in[ST_VY] = ivy_ff;
                  state_in = S_STORE;
               end else if (imu_present_ff) begin
                  state_in = S_OPA;
               end else begin
                  state_in = S_STORE;
               end
            end
         end
         S_OPA: state_in = S_OPB;
         S_OPB: begin
            op_in    = op_ff + 1'b1;
            state_in = S_OPA;
            case (op_ff)
               OP_DTDT: begin
                  hd2_in = 17'((prod_w + (wide_type'(1) <<< 16)) >>> 17);
                  d2_in  = 17'(dd >>> 16);
               end
               OP_HDHD: q4_in = 17'(dd >>> 16);
               OP_QUAD: begin
                  nq_in = nw[1:0];
                  rr_in = 32'(rem >>> FRAC_BITS);
               end
               OP_ZANG: state_in = S_CORD;
               OP_CAX:  acc_in = prod_w;
               OP_SAY: begin
                  e1_in  = sat32(rnd(acc_ff - prod_w, 30));
                  awx_in = sat32(wide_type'(sat32(rnd(acc_ff - prod_w, 30)))
                                 + wide_type'(gravity_x_ff));
               end
               OP_SAX:  acc_in = prod_w;
               OP_CAY: begin
                  e2_in  = sat32(rnd(acc_ff + prod_w, 30));
                  awy_in = sat32(wide_type'(sat32(rnd(acc_ff + prod_w, 30)))
                                 + wide_type'(gravity_y_ff));
               end
               OP_HEAD: st_in[ST_HD] = sat32(wide_type'(st_ff[ST_HD]) + wide_type'(md));
               OP_PX1:  acc_in = wide_type'(st_ff[ST_PX]) + wide_type'(md);
               OP_PX2:  st_in[ST_PX] = sat32(acc_ff + wide_type'(md));
               OP_PY1:  acc_in = wide_type'(st_ff[ST_PY]) + wide_type'(md);
               OP_PY2:  st_in[ST_PY] = sat32(acc_ff + wide_type'(md));
               OP_VX:   st_in[ST_VX] = sat32(wide_type'(st_ff[ST_VX]) + wide_type'(md));
               OP_VY:   st_in[ST_VY] = sat32(wide_type'(st_ff[ST_VY]) + wide_type'(md));
               OP_A:    a_in = md;
               OP_B:    b_in = md;
               OP_ACCV: accv_in = satu31(rnd(prod_w, FRAC_BITS));
               OP_GYRV: gyrv_in = satu31(rnd(prod_w, FRAC_BITS));
               OP_QP:   qp_in = md;
               OP_XX1:  acc_in = wide_type'(st_ff[ST_XX]) + (wide_type'(mq) <<< 1)
                                 + wide_type'(qp_ff);
               OP_XX2, OP_XY3, OP_YY2: t1_in = mq;
               OP_XX3:  st_in[ST_XX] = satu31(acc_ff + wide_type'(mq));
               OP_XY1:  acc_in = wide_type'(st_ff[ST_XY]) + wide_type'(mq);
               OP_XY2:  acc_in = acc_ff + wide_type'(mq);
               OP_XY4:  st_in[ST_XY] = sat32(acc_ff + wide_type'(mq));
               OP_YY1:  acc_in = wide_type'(st_ff[ST_YY]) + (wide_type'(mq) <<< 1)
                                 + wide_type'(qp_ff);
               OP_YY3:  st_in[ST_YY] = satu31(acc_ff + wide_type'(mq));
               OP_XH:   st_in[ST_XH] = sat32(wide_type'(st_ff[ST_XH]) + wide_type'(mq));
               OP_YH:   st_in[ST_YH] = sat32(wide_type'(st_ff[ST_YH]) + wide_type'(mq));
               OP_HH:   st_in[ST_HH] = satu31(wide_type'(st_ff[ST_HH]) + wide_type'(md));
               OP_VV: begin
                  st_in[ST_VV] = satu31(wide_type'(st_ff[ST_VV]) + wide_type'(md));
                  cnt_in   = '0;
                  state_in = S_STORE;
               end
               default: ;
            endcase
         end
         S_CORD: begin
            if (cord_done) begin
               case (nq_ff)
                  QUAD_0:  begin c_in = cord_c;  s_in = cord_s;  end
                  QUAD_1:  begin c_in = -cord_s; s_in = cord_c;  end
                  QUAD_2:  begin c_in = -cord_c; s_in = -cord_s; end
                  default: begin c_in = cord_s;  s_in = -cord_c; end
               endcase
               state_in = S_OPA;
            end
         end
         S_STORE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(NUM_ENTRIES - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_in       = st_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= OP_DTDT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
      end
      st_in_copy: for (int i = 0; i < NUM_ENTRIES; i++) begin
         st_ff[i]  <= st_in[i];
         out_ff[i] <= out_in[i];
      end
      action_ff <= action_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      w_ff      <= w_in;
      dt_ff     <= dt_in;
      ipx_ff    <= ipx_in;
      ipy_ff    <= ipy_in;
      ihd_ff    <= ihd_in;
      ivx_ff    <= ivx_in;
      ivy_ff    <= ivy_in;
      hd2_ff    <= hd2_in;
      d2_ff     <= d2_in;
      q4_ff     <= q4_in;
      nq_ff     <= nq_in;
      rr_ff     <= rr_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      awx_ff    <= awx_in;
      awy_ff    <= awy_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      accv_ff   <= accv_in;
      gyrv_ff   <= gyrv_in;
      qp_ff     <= qp_in;
      t1_ff     <= t1_in;
      acc_ff    <= acc_in;
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_pos_x    = out_ff[ST_PX];
   assign rsp_bus.out_pos_y    = out_ff[ST_PY];
   assign rsp_bus.out_heading  = out_ff[ST_HD];
   assign rsp_bus.out_vel_x    = out_ff[ST_VX];
   assign rsp_bus.out_vel_y    = out_ff[ST_VY];
   assign rsp_bus.cov_xx       = out_ff[ST_XX][30:0];
   assign rsp_bus.cov_xy       = out_ff[ST_XY];
   assign rsp_bus.cov_xh       = out_ff[ST_XH];
   assign rsp_bus.cov_yy       = out_ff[ST_YY][30:0];
   assign rsp_bus.cov_yh       = out_ff[ST_YH];
   assign rsp_bus.cov_hh       = out_ff[ST_HH][30:0];
   assign rsp_bus.vel_variance = out_ff[ST_VV][30:0];

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == S_LOAD)
      else $error("accepted beat did not start the state read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result beat raised outside the done state");

   a_done_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished item not moved into a free result slot");

   a_store_only_at_end: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && cnt_ff == ADDR_W'(NUM_ENTRIES - 1) |=> state_ff == S_DONE)
      else $error("write back did not end in the done state");
endmodule
`default_nettype wire
